>>> hdl/upsr_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and result record for the update package section router
package upsr_pkg;

	localparam int HEADER_BYTES = 32;
	localparam int META_BYTES   = 64;
	localparam int HDR_STORE    = 20;

	localparam int HCNT_W = 6;
	localparam int MCNT_W = 7;
	localparam int PCNT_W = 24;
	localparam int SCNT_W = 16;
	localparam int OFF_W  = 24;
	localparam int TOT_W  = 26;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;

	localparam logic [CFG_AW-1:0] CFG_FILE_SIZE   = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] CFG_MAGIC       = CFG_AW'(1);
	localparam logic [CFG_AW-1:0] CFG_FULL_TYPE   = CFG_AW'(2);
	localparam logic [CFG_AW-1:0] CFG_DELTA_TYPE  = CFG_AW'(3);
	localparam logic [CFG_AW-1:0] CFG_MAX_FW      = CFG_AW'(4);
	localparam logic [CFG_AW-1:0] CFG_MAX_SIG     = CFG_AW'(5);

	localparam logic [1:0] SEC_HEADER    = 2'd0;
	localparam logic [1:0] SEC_META      = 2'd1;
	localparam logic [1:0] SEC_PAYLOAD   = 2'd2;
	localparam logic [1:0] SEC_SIGNATURE = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_MAGIC  = 3'd1;
	localparam logic [2:0] ST_TYPE   = 3'd2;
	localparam logic [2:0] ST_FW     = 3'd3;
	localparam logic [2:0] ST_SIG    = 3'd4;
	localparam logic [2:0] ST_TOTAL  = 3'd5;
	localparam logic [2:0] ST_EXCESS = 3'd6;

	localparam logic CMD_DATA    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef struct packed {
		logic [1:0]       section;
		logic [OFF_W-1:0] offset;
		logic [7:0]       byte_out;
		logic             write_valid;
		logic             header_valid;
		logic             package_kind;
		logic [2:0]       status;
		logic             complete;
		logic             last;
	} result_t;

endpackage

>>> hdl/update_package_section_router.sv
`timescale 1ns / 1ps
// top level of the update package section router
//
//  channel   dir  signals                         contents
//  s_*       in   s_tdata[7:0]                    data_byte
//                 s_tuser                         cmd
//                 s_tlast                         chunk_last
//  m_*       out  m_tdata[39:0]                   see port comment
//                 m_tuser[1:0]                    section
//                 m_tlast                         chunk_last_out
//  cfg_*     in   cfg_we, cfg_addr, cfg_wdata     register writes
//
//  one request per cycle while the queue is not full; a result goes through queue and output register
//  the header check runs in the cycle of the last header byte, in the front end
//  a four-entry result queue and an output register let the output stall apart
//  from the input; s_tready drops only when the queue is full
//  reset clears all counters and flags at once; no clearing pass
module update_package_section_router (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [upsr_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [upsr_pkg::CFG_DW-1:0]    cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [upsr_pkg::S_TDATA_W-1:0] s_tdata,   // data_byte
	input  logic                           s_tuser,   // cmd
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// section_offset[23:0], byte_out[31:24], write_valid[32], header_valid[33],
	// package_kind[34], status[37:35], package_complete[38], zero[39]
	output logic [upsr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [1:0]                     m_tuser,   // section
	output logic                           m_tlast
);

	upsr_pkg::result_t front_res;
	upsr_pkg::result_t q_data;
	logic              push;
	logic              q_full;
	logic              q_valid;
	logic              pop;

	upsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.res       (front_res)
	);

	upsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_res),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	upsr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> hdl/upsr_front.sv
`timescale 1ns / 1ps
// front end: config registers, session counters, header check and byte classification
module upsr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [upsr_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [upsr_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [upsr_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic                          q_full,
	output logic                          push,
	output upsr_pkg::result_t             res
);

	logic [23:0] file_size_q;
	logic [31:0] magic_q;
	logic [31:0] full_type_q;
	logic [31:0] delta_type_q;
	logic [23:0] max_fw_q;
	logic [15:0] max_sig_q;

	logic [upsr_pkg::HCNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [upsr_pkg::MCNT_W-1:0] meta_cnt_q, meta_cnt_d;
	logic [upsr_pkg::PCNT_W-1:0] pay_cnt_q, pay_cnt_d;
	logic [upsr_pkg::SCNT_W-1:0] sig_cnt_q, sig_cnt_d;
	logic [23:0] fw_len_q, fw_len_d;
	logic [15:0] sig_len_q, sig_len_d;
	logic        hdr_ready_q, hdr_ready_d;
	logic        kind_q, kind_d;
	logic [2:0]  err_q, err_d;
	logic [7:0]  hdr_bytes_q [upsr_pkg::HDR_STORE];
	logic [7:0]  hdr_view [upsr_pkg::HDR_STORE];

	logic [31:0] w_magic, w_hsize, w_ptype, w_fw, w_sig;
	logic [upsr_pkg::TOT_W-1:0] total;
	logic [2:0]  chk_code;
	logic        live;
	logic        hdr_last;
	logic        cmd;

	assign cmd      = s_tuser;
	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;
	assign live     = (err_q == upsr_pkg::ST_OK);
	assign hdr_last = (hdr_cnt_q == upsr_pkg::HCNT_W'(upsr_pkg::HEADER_BYTES - 1));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q  <= '0;
			magic_q      <= '0;
			full_type_q  <= '0;
			delta_type_q <= 32'd1;
			max_fw_q     <= 24'd1048576;
			max_sig_q    <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_addr)
				upsr_pkg::CFG_FILE_SIZE:  file_size_q  <= cfg_wdata[23:0];
				upsr_pkg::CFG_MAGIC:      magic_q      <= cfg_wdata;
				upsr_pkg::CFG_FULL_TYPE:  full_type_q  <= cfg_wdata;
				upsr_pkg::CFG_DELTA_TYPE: delta_type_q <= cfg_wdata;
				upsr_pkg::CFG_MAX_FW:     max_fw_q     <= cfg_wdata[23:0];
				upsr_pkg::CFG_MAX_SIG:    max_sig_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// header bytes with the incoming byte merged in
	always_comb begin
		for (int i = 0; i < upsr_pkg::HDR_STORE; i++) begin
			hdr_view[i] = (hdr_cnt_q == upsr_pkg::HCNT_W'(i)) ? s_tdata : hdr_bytes_q[i];
		end
	end

	assign w_magic = {hdr_view[3],  hdr_view[2],  hdr_view[1],  hdr_view[0]};
	assign w_hsize = {hdr_view[7],  hdr_view[6],  hdr_view[5],  hdr_view[4]};
	assign w_ptype = {hdr_view[11], hdr_view[10], hdr_view[9],  hdr_view[8]};
	assign w_fw    = {hdr_view[15], hdr_view[14], hdr_view[13], hdr_view[12]};
	assign w_sig   = {hdr_view[19], hdr_view[18], hdr_view[17], hdr_view[16]};

	assign total = upsr_pkg::TOT_W'(upsr_pkg::HEADER_BYTES + upsr_pkg::META_BYTES)
		+ {2'b00, w_fw[23:0]} + {10'd0, w_sig[15:0]};

	// first failing check wins
	always_comb begin
		if (w_magic != magic_q || w_hsize != 32'(upsr_pkg::HEADER_BYTES)) begin
			chk_code = upsr_pkg::ST_MAGIC;
		end else if (w_ptype != full_type_q && w_ptype != delta_type_q) begin
			chk_code = upsr_pkg::ST_TYPE;
		end else if (w_fw == 32'd0 || w_fw > {8'd0, max_fw_q}) begin
			chk_code = upsr_pkg::ST_FW;
		end else if (w_sig == 32'd0 || w_sig > {16'd0, max_sig_q}) begin
			chk_code = upsr_pkg::ST_SIG;
		end else if (total != {2'b00, file_size_q}) begin
			chk_code = upsr_pkg::ST_TOTAL;
		end else begin
			chk_code = upsr_pkg::ST_OK;
		end
	end

	// classify the request and work out the next session state
	always_comb begin
		hdr_cnt_d   = hdr_cnt_q;
		meta_cnt_d  = meta_cnt_q;
		pay_cnt_d   = pay_cnt_q;
		sig_cnt_d   = sig_cnt_q;
		fw_len_d    = fw_len_q;
		sig_len_d   = sig_len_q;
		hdr_ready_d = hdr_ready_q;
		kind_d      = kind_q;
		err_d       = err_q;

		res              = '0;
		res.byte_out     = s_tdata;
		res.last         = s_tlast;

		if (cmd == upsr_pkg::CMD_RESTART) begin
			hdr_cnt_d    = '0;
			meta_cnt_d   = '0;
			pay_cnt_d    = '0;
			sig_cnt_d    = '0;
			fw_len_d     = '0;
			sig_len_d    = '0;
			hdr_ready_d  = 1'b0;
			kind_d       = 1'b0;
			err_d        = upsr_pkg::ST_OK;
			res.section  = upsr_pkg::SEC_HEADER;
			res.offset   = '0;
			res.byte_out = '0;
		end else if (hdr_cnt_q < upsr_pkg::HCNT_W'(upsr_pkg::HEADER_BYTES)) begin
			res.section = upsr_pkg::SEC_HEADER;
			res.offset  = upsr_pkg::OFF_W'(hdr_cnt_q);
			if (live) begin
				hdr_cnt_d       = hdr_cnt_q + 1'b1;
				res.write_valid = 1'b1;
				if (hdr_last) begin
					err_d = chk_code;
					if (chk_code != upsr_pkg::ST_OK) begin
						res.write_valid = 1'b0;
					end else begin
						res.header_valid = 1'b1;
						fw_len_d    = w_fw[23:0];
						sig_len_d   = w_sig[15:0];
						kind_d      = (w_ptype != full_type_q);
						hdr_ready_d = 1'b1;
					end
				end
			end
		end else if (meta_cnt_q < upsr_pkg::MCNT_W'(upsr_pkg::META_BYTES)) begin
			res.section = upsr_pkg::SEC_META;
			res.offset  = upsr_pkg::OFF_W'(meta_cnt_q);
			if (live) begin
				meta_cnt_d      = meta_cnt_q + 1'b1;
				res.write_valid = 1'b1;
			end
		end else if (pay_cnt_q < fw_len_q) begin
			res.section = upsr_pkg::SEC_PAYLOAD;
			res.offset  = pay_cnt_q;
			if (live) begin
				pay_cnt_d       = pay_cnt_q + 1'b1;
				res.write_valid = 1'b1;
			end
		end else if (sig_cnt_q < sig_len_q) begin
			res.section = upsr_pkg::SEC_SIGNATURE;
			res.offset  = upsr_pkg::OFF_W'(sig_cnt_q);
			if (live) begin
				sig_cnt_d       = sig_cnt_q + 1'b1;
				res.write_valid = 1'b1;
			end
		end else begin
			res.section = upsr_pkg::SEC_SIGNATURE;
			res.offset  = upsr_pkg::OFF_W'(sig_len_q);
			if (live) begin
				err_d = upsr_pkg::ST_EXCESS;
			end
		end

		res.package_kind = kind_d;
		res.status       = err_d;
		res.complete     = (err_d == upsr_pkg::ST_OK) && hdr_ready_d
			&& (meta_cnt_d == upsr_pkg::MCNT_W'(upsr_pkg::META_BYTES))
			&& (pay_cnt_d == fw_len_d) && (sig_cnt_d == sig_len_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			meta_cnt_q  <= '0;
			pay_cnt_q   <= '0;
			sig_cnt_q   <= '0;
			fw_len_q    <= '0;
			sig_len_q   <= '0;
			hdr_ready_q <= 1'b0;
			kind_q      <= 1'b0;
			err_q       <= upsr_pkg::ST_OK;
		end else if (push) begin
			hdr_cnt_q   <= hdr_cnt_d;
			meta_cnt_q  <= meta_cnt_d;
			pay_cnt_q   <= pay_cnt_d;
			sig_cnt_q   <= sig_cnt_d;
			fw_len_q    <= fw_len_d;
			sig_len_q   <= sig_len_d;
			hdr_ready_q <= hdr_ready_d;
			kind_q      <= kind_d;
			err_q       <= err_d;
		end
	end

	// header byte store, written only while counting the first bytes
	always_ff @(posedge clk) begin
		for (int i = 0; i < upsr_pkg::HDR_STORE; i++) begin
			if (push && cmd == upsr_pkg::CMD_DATA && live
					&& hdr_cnt_q == upsr_pkg::HCNT_W'(i)) begin
				hdr_bytes_q[i] <= s_tdata;
			end
		end
	end

	a_hv_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.header_valid |=> hdr_ready_q && err_q == upsr_pkg::ST_OK)
		else $error("header pass did not arm the session");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd == upsr_pkg::CMD_RESTART |=> err_q == upsr_pkg::ST_OK
		&& hdr_cnt_q == '0 && !hdr_ready_q)
		else $error("restart left session state behind");

	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd == upsr_pkg::CMD_DATA && !live |=> $stable(err_q)
		&& $stable(hdr_cnt_q) && $stable(pay_cnt_q) && $stable(sig_cnt_q))
		else $error("state moved while an error was held");

	a_write_only_live: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.write_valid |-> live && res.status == upsr_pkg::ST_OK)
		else $error("write flagged under error");

endmodule

>>> hdl/upsr_queue.sv
`timescale 1ns / 1ps
// short result queue between the front and back ends
module upsr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  upsr_pkg::result_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output upsr_pkg::result_t q_data
);

	upsr_pkg::result_t           slot_q [upsr_pkg::QUEUE_DEPTH];
	logic [upsr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [upsr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [upsr_pkg::QPTR_W:0]   cnt_q;

	assign full    = (cnt_q == (upsr_pkg::QPTR_W + 1)'(upsr_pkg::QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hdl/upsr_back.sv
`timescale 1ns / 1ps
// back end: output register and stream packing of results
module upsr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  upsr_pkg::result_t              q_data,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [upsr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	upsr_pkg::result_t out_q;
	logic              valid_q;

	assign pop      = q_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tuser  = out_q.section;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {1'b0, out_q.complete, out_q.status, out_q.package_kind,
		out_q.header_valid, out_q.write_valid, out_q.byte_out, out_q.offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_data;
		end
	end

endmodule

>>> verif/update_package_section_router_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the update package section router: random packages, stalls, registers
module update_package_section_router_tb;

	localparam int ITEM_TARGET = 1900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int STREAM_CAP  = 48;

	typedef struct {
		bit       cmd;
		bit [7:0] data;
		bit       last;
		int       gap;
		bit       drain;
	} request_t;

	typedef enum int {
		PK_GOOD, PK_MAGIC, PK_HSIZE, PK_TYPE, PK_FW_ZERO, PK_FW_BIG,
		PK_SIG_ZERO, PK_SIG_BIG, PK_TOTAL, PK_CUT, PK_NOISE
	} pkg_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [upsr_pkg::CFG_AW-1:0]    cfg_addr = '0;
	logic [upsr_pkg::CFG_DW-1:0]    cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [upsr_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [upsr_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;
	logic                           m_tlast;

	update_package_section_router dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	// register copies
	bit [23:0] lim_file_size = 24'd0;
	bit [31:0] lim_magic     = 32'd0;
	bit [31:0] lim_full      = 32'd0;
	bit [31:0] lim_delta     = 32'd1;
	bit [23:0] lim_max_fw    = 24'd1048576;
	bit [15:0] lim_max_sig   = 16'd256;

	// session state
	bit [5:0]  hdr_cnt = '0;
	bit [6:0]  meta_cnt = '0;
	bit [23:0] pay_cnt = '0;
	bit [15:0] sig_cnt = '0;
	bit [7:0]  hdr_store [upsr_pkg::HDR_STORE];
	bit [23:0] fw_len = '0;
	bit [15:0] sig_len = '0;
	bit        hdr_ok = 1'b0;
	bit        img_kind = 1'b0;
	bit [2:0]  err_code = upsr_pkg::ST_OK;

	request_t          feed_q[$];
	upsr_pkg::result_t expect_q[$];
	upsr_pkg::result_t predicted;
	upsr_pkg::result_t wanted;
	upsr_pkg::result_t seen;

	request_t cur_rq;
	bit       have_cur = 1'b0;
	int       gap_left = 0;
	int       stall_left = 0;
	bit       rx_calm = 1'b0;
	int       rx_done = 0;

	int unsigned cycles = 0;
	int          queued = 0;
	int          checked = 0;
	int          mismatches = 0;
	int          hv_seen = 0;
	int          done_seen = 0;
	int          phases = 0;
	bit [7:0]    status_mask = '0;

	function automatic bit [31:0] hdr_word(input int b);
		return {hdr_store[b+3], hdr_store[b+2], hdr_store[b+1], hdr_store[b]};
	endfunction

	// checks run in priority order; on success latches lengths and kind
	function automatic bit [2:0] header_verdict();
		bit [31:0] magic, hsize, ptype, fw, sig;
		longint    total;
		magic = hdr_word(0);
		hsize = hdr_word(4);
		ptype = hdr_word(8);
		fw    = hdr_word(12);
		sig   = hdr_word(16);
		if (magic != lim_magic || hsize != 32'(upsr_pkg::HEADER_BYTES))
			return upsr_pkg::ST_MAGIC;
		if (ptype != lim_full && ptype != lim_delta)
			return upsr_pkg::ST_TYPE;
		if (fw == 0 || fw > 32'(lim_max_fw))
			return upsr_pkg::ST_FW;
		if (sig == 0 || sig > 32'(lim_max_sig))
			return upsr_pkg::ST_SIG;
		total = longint'(upsr_pkg::HEADER_BYTES) + longint'(upsr_pkg::META_BYTES)
			+ longint'(fw) + longint'(sig);
		if (total != longint'(lim_file_size))
			return upsr_pkg::ST_TOTAL;
		fw_len   = fw[23:0];
		sig_len  = sig[15:0];
		img_kind = (ptype == lim_full) ? 1'b0 : 1'b1;
		hdr_ok   = 1'b1;
		return upsr_pkg::ST_OK;
	endfunction

	task automatic route_request(input bit cmd, input bit [7:0] d, input bit lst,
	                             output upsr_pkg::result_t r);
		bit live;
		live = (err_code == upsr_pkg::ST_OK);
		r = '0;
		r.byte_out = d;
		r.last = lst;
		if (cmd == upsr_pkg::CMD_RESTART) begin
			hdr_cnt = '0;
			meta_cnt = '0;
			pay_cnt = '0;
			sig_cnt = '0;
			fw_len = '0;
			sig_len = '0;
			hdr_ok = 1'b0;
			img_kind = 1'b0;
			err_code = upsr_pkg::ST_OK;
			r.section = upsr_pkg::SEC_HEADER;
			r.offset = '0;
			r.byte_out = '0;
		end else if (hdr_cnt < upsr_pkg::HEADER_BYTES) begin
			r.section = upsr_pkg::SEC_HEADER;
			r.offset = 24'(hdr_cnt);
			if (live) begin
				if (hdr_cnt < upsr_pkg::HDR_STORE)
					hdr_store[hdr_cnt] = d;
				hdr_cnt++;
				r.write_valid = 1'b1;
				if (hdr_cnt == upsr_pkg::HEADER_BYTES) begin
					err_code = header_verdict();
					if (err_code != upsr_pkg::ST_OK)
						r.write_valid = 1'b0;
					else
						r.header_valid = 1'b1;
				end
			end
		end else if (meta_cnt < upsr_pkg::META_BYTES) begin
			r.section = upsr_pkg::SEC_META;
			r.offset = 24'(meta_cnt);
			if (live) begin
				meta_cnt++;
				r.write_valid = 1'b1;
			end
		end else if (pay_cnt < fw_len) begin
			r.section = upsr_pkg::SEC_PAYLOAD;
			r.offset = pay_cnt;
			if (live) begin
				pay_cnt++;
				r.write_valid = 1'b1;
			end
		end else if (sig_cnt < sig_len) begin
			r.section = upsr_pkg::SEC_SIGNATURE;
			r.offset = 24'(sig_cnt);
			if (live) begin
				sig_cnt++;
				r.write_valid = 1'b1;
			end
		end else begin
			// byte past the end of the signature
			r.section = upsr_pkg::SEC_SIGNATURE;
			r.offset = 24'(sig_len);
			if (live)
				err_code = upsr_pkg::ST_EXCESS;
		end
		r.package_kind = img_kind;
		r.status = err_code;
		r.complete = (err_code == upsr_pkg::ST_OK) && hdr_ok &&
		             (meta_cnt == upsr_pkg::META_BYTES) &&
		             (pay_cnt == fw_len) && (sig_cnt == sig_len);
	endtask

	function automatic string show(input upsr_pkg::result_t r);
		return $sformatf("sec=%0d off=%0d byte=%02h wv=%0b hv=%0b kind=%0b st=%0d done=%0b last=%0b",
		                 r.section, r.offset, r.byte_out, r.write_valid, r.header_valid,
		                 r.package_kind, r.status, r.complete, r.last);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (!have_cur && feed_q.size() != 0) begin
				cur_rq = feed_q.pop_front();
				have_cur = 1'b1;
				gap_left = cur_rq.gap;
			end
			if (!have_cur || gap_left > 0 ||
			    (cur_rq.drain && (expect_q.size() != 0 || s_tvalid))) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= cur_rq.data;
				s_tuser  <= cur_rq.cmd;
				s_tlast  <= cur_rq.last;
				have_cur = 1'b0;
			end
		end
	end

	// accepted requests feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			route_request(s_tuser, s_tdata, s_tlast, predicted);
			expect_q.push_back(predicted);
		end
	end

	// result side ready, with one long hold-off now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rx_done++;
				if (rx_done % 128 == 0)
					rx_calm = ($urandom_range(0, 3) == 0);
				if (rx_done % 900 == 350)
					stall_left = HOLD_CYCLES;
				else
					stall_left = rx_calm ? 0 : $urandom_range(0, 6);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.section      = m_tuser;
			seen.offset       = m_tdata[23:0];
			seen.byte_out     = m_tdata[31:24];
			seen.write_valid  = m_tdata[32];
			seen.header_valid = m_tdata[33];
			seen.package_kind = m_tdata[34];
			seen.status       = m_tdata[37:35];
			seen.complete     = m_tdata[38];
			seen.last         = m_tlast;
			if (expect_q.size() == 0) begin
				if (mismatches < 10)
					$display("[%0t] result with no request pending: %s", $time, show(seen));
				mismatches++;
			end else begin
				wanted = expect_q.pop_front();
				checked++;
				hv_seen += wanted.header_valid;
				done_seen += wanted.complete;
				status_mask[wanted.status] = 1'b1;
				if (seen.section !== wanted.section || seen.offset !== wanted.offset ||
				    seen.byte_out !== wanted.byte_out ||
				    seen.write_valid !== wanted.write_valid ||
				    seen.header_valid !== wanted.header_valid ||
				    seen.package_kind !== wanted.package_kind ||
				    seen.status !== wanted.status || seen.complete !== wanted.complete ||
				    seen.last !== wanted.last ||
				    m_tdata[upsr_pkg::M_TDATA_W-1] !== 1'b0) begin
					if (mismatches < 10) begin
						$display("[%0t] mismatch on result %0d", $time, checked);
						$display("  expected %s", show(wanted));
						$display("  actual   %s pad=%b", show(seen),
						         m_tdata[upsr_pkg::M_TDATA_W-1]);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, expect_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_reg(input logic [upsr_pkg::CFG_AW-1:0] idx,
	                         input logic [upsr_pkg::CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			upsr_pkg::CFG_FILE_SIZE:  lim_file_size = val[23:0];
			upsr_pkg::CFG_MAGIC:      lim_magic = val;
			upsr_pkg::CFG_FULL_TYPE:  lim_full = val;
			upsr_pkg::CFG_DELTA_TYPE: lim_delta = val;
			upsr_pkg::CFG_MAX_FW:     lim_max_fw = val[23:0];
			upsr_pkg::CFG_MAX_SIG:    lim_max_sig = val[15:0];
			default: ;
		endcase
	endtask

	// unused upper data bits carry noise
	task automatic program_setting(input bit [23:0] fsz, input bit [31:0] magic,
	                               input bit [31:0] full, input bit [31:0] delta,
	                               input bit [23:0] mfw, input bit [15:0] msig);
		write_reg(upsr_pkg::CFG_FILE_SIZE, {8'($urandom), fsz});
		write_reg(upsr_pkg::CFG_MAGIC, magic);
		write_reg(upsr_pkg::CFG_FULL_TYPE, full);
		write_reg(upsr_pkg::CFG_DELTA_TYPE, delta);
		write_reg(upsr_pkg::CFG_MAX_FW, {8'($urandom), mfw});
		write_reg(upsr_pkg::CFG_MAX_SIG, {16'($urandom), msig});
		@(posedge clk);
		cfg_we <= 1'b0;
		phases++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (feed_q.size() != 0 || have_cur || s_tvalid || expect_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic request_t make_rq(input bit cmd, input bit [7:0] d);
		request_t rq;
		rq.cmd = cmd;
		rq.data = d;
		rq.last = ($urandom_range(0, 3) == 0);
		rq.gap = 0;
		rq.drain = 1'b0;
		return rq;
	endfunction

	function automatic pkg_mode_t pick_mode();
		case ($urandom_range(0, 19))
			10: return PK_MAGIC;
			11: return PK_HSIZE;
			12: return PK_TYPE;
			13: return PK_FW_ZERO;
			14: return PK_FW_BIG;
			15: return PK_SIG_ZERO;
			16: return PK_SIG_BIG;
			17: return PK_TOTAL;
			18: return PK_CUT;
			19: return PK_NOISE;
			default: return PK_GOOD;
		endcase
	endfunction

	// one restart-led package for the current registers, possibly broken as the mode says
	task automatic queue_package(input pkg_mode_t mode);
		request_t  run[$];
		bit [7:0]  hdr [upsr_pkg::HEADER_BYTES];
		bit [31:0] magic, hsize, ptype, fw, sig;
		longint    body, lo, hi;
		int        n_pay, n_sig, keep;
		bit        calm;
		run.push_back(make_rq(upsr_pkg::CMD_RESTART, 8'($urandom)));
		if (mode == PK_NOISE) begin
			repeat ($urandom_range(1, 20))
				run.push_back(make_rq($urandom_range(0, 7) == 0, 8'($urandom)));
		end else begin
			magic = lim_magic;
			hsize = upsr_pkg::HEADER_BYTES;
			ptype = $urandom_range(0, 1) ? lim_full : lim_delta;
			body = longint'(lim_file_size) - upsr_pkg::HEADER_BYTES - upsr_pkg::META_BYTES;
			lo = (body - longint'(lim_max_sig) > 1) ? body - longint'(lim_max_sig) : 1;
			hi = (body - 1 < longint'(lim_max_fw)) ? body - 1 : longint'(lim_max_fw);
			if (body >= 2 && lo <= hi) begin
				fw = $urandom_range(int'(hi), int'(lo));
				sig = 32'(body) - fw;
			end else begin
				fw = $urandom_range(1, 24);
				sig = $urandom_range(1, 12);
			end
			case (mode)
				PK_MAGIC:    magic ^= 32'd1 << $urandom_range(0, 31);
				PK_HSIZE:    hsize ^= 32'd1 << $urandom_range(0, 31);
				PK_TYPE: begin
					ptype = $urandom;
					while (ptype == lim_full || ptype == lim_delta)
						ptype++;
				end
				PK_FW_ZERO:  fw = 0;
				PK_FW_BIG:   fw = $urandom_range(0, 1)
				                  ? 32'(lim_max_fw) + 1 + $urandom_range(0, 4096)
				                  : $urandom | 32'h0100_0000;
				PK_SIG_ZERO: sig = 0;
				PK_SIG_BIG:  sig = $urandom_range(0, 1)
				                   ? 32'(lim_max_sig) + 1 + $urandom_range(0, 4096)
				                   : $urandom | 32'h0001_0000;
				PK_TOTAL: begin
					if (sig < lim_max_sig)
						sig++;
					else if (fw < lim_max_fw)
						fw++;
					else
						fw--;
				end
				default: ;
			endcase
			for (int i = 0; i < 4; i++) begin
				hdr[i]      = magic[8*i +: 8];
				hdr[4 + i]  = hsize[8*i +: 8];
				hdr[8 + i]  = ptype[8*i +: 8];
				hdr[12 + i] = fw[8*i +: 8];
				hdr[16 + i] = sig[8*i +: 8];
			end
			for (int i = upsr_pkg::HDR_STORE; i < upsr_pkg::HEADER_BYTES; i++)
				hdr[i] = 8'($urandom);
			for (int i = 0; i < upsr_pkg::HEADER_BYTES; i++)
				run.push_back(make_rq(upsr_pkg::CMD_DATA, hdr[i]));
			if (mode == PK_GOOD || mode == PK_CUT) begin
				n_pay = (fw > STREAM_CAP) ? STREAM_CAP : int'(fw);
				n_sig = (fw > STREAM_CAP) ? 0 : ((sig > STREAM_CAP) ? STREAM_CAP : int'(sig));
				repeat (upsr_pkg::META_BYTES + n_pay + n_sig)
					run.push_back(make_rq(upsr_pkg::CMD_DATA, 8'($urandom)));
				if (fw <= STREAM_CAP && sig <= STREAM_CAP && $urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 5))
						run.push_back(make_rq(upsr_pkg::CMD_DATA, 8'($urandom)));
				if (mode == PK_CUT) begin
					keep = $urandom_range(2, run.size() - 1);
					while (run.size() > keep)
						void'(run.pop_back());
				end
			end else begin
				repeat ($urandom_range(0, 6))
					run.push_back(make_rq(upsr_pkg::CMD_DATA, 8'($urandom)));
			end
		end
		calm = ($urandom_range(0, 3) == 0);
		run[0].drain = ($urandom_range(0, 5) == 0);
		foreach (run[i]) begin
			run[i].gap = calm ? 0 : $urandom_range(0, 6);
			feed_q.push_back(run[i]);
		end
		queued += run.size();
	endtask

	initial begin
		bit [31:0] fc, dc;
		bit [23:0] mf;
		bit [15:0] ms;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// restart and field extremes under the reset register values
		feed_q.push_back('{upsr_pkg::CMD_RESTART, 8'hFF, 1'b1, 0, 1'b0});
		feed_q.push_back('{upsr_pkg::CMD_DATA, 8'h00, 1'b0, 0, 1'b0});
		feed_q.push_back('{upsr_pkg::CMD_DATA, 8'hFF, 1'b1, 2, 1'b0});
		feed_q.push_back('{upsr_pkg::CMD_DATA, 8'hA5, 1'b0, 0, 1'b0});
		feed_q.push_back('{upsr_pkg::CMD_RESTART, 8'h00, 1'b0, 1, 1'b0});
		queued += 5;
		queue_package(PK_GOOD);
		queue_package(PK_HSIZE);

		for (int phase = 1; queued < ITEM_TARGET || phase < 5; phase++) begin
			wait_idle();
			case (phase)
				1: program_setting(24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
				                   24'hFFFFFF, 16'hFFFF);
				2: begin
					fc = $urandom;
					program_setting(24'(upsr_pkg::HEADER_BYTES + upsr_pkg::META_BYTES + 2),
					                $urandom, fc, fc, 24'd1, 16'd1);
				end
				3: program_setting(24'd0, 32'h0, $urandom, $urandom, 24'($urandom_range(1, 40)),
				                   16'($urandom_range(1, 20)));
				default: begin
					mf = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom_range(1, 60));
					ms = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 30));
					fc = $urandom;
					dc = ($urandom_range(0, 7) == 0) ? fc : $urandom;
					program_setting(24'(upsr_pkg::HEADER_BYTES + upsr_pkg::META_BYTES
					                    + $urandom_range(2, 70)),
					                $urandom, fc, dc, mf, ms);
				end
			endcase
			if (phase == 1)
				queue_package(PK_GOOD);
			repeat ($urandom_range(2, 5))
				queue_package(pick_mode());
		end

		wait_idle();
		mismatches += expect_q.size();
		$display("run covered %0d requests over %0d register configurations, %0d results checked",
		         queued, phases, checked);
		$display("headers accepted %0d, packages completed %0d, status codes seen %b",
		         hv_seen, done_seen, status_mask[6:0]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
hdl/upsr_pkg.sv
hdl/upsr_front.sv
hdl/upsr_queue.sv
hdl/upsr_back.sv
hdl/update_package_section_router.sv
verif/update_package_section_router_tb.sv
